@@ rtl/core/antialiased_line_rasterizer_core_macros.svh @@
// assertion macros for the antialiased line rasterizer core
// used by the port checker, expects clk and rst_n in the including scope
`ifndef ANTIALIASED_LINE_RASTERIZER_CORE_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication
`define AALR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aalr port check failed");

// next-cycle implication
`define AALR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aalr port check failed");

`endif

@@ rtl/core/aalr_pkg.sv @@
// shared types and codes for the antialiased line rasterizer core
// no dependencies
`default_nettype none

package aalr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic [2:0] res_sel_t;

  localparam res_sel_t RES_EP0   = 3'd0;
  localparam res_sel_t RES_EP1   = 3'd1;
  localparam res_sel_t RES_UPPER = 3'd2;
  localparam res_sel_t RES_LOWER = 3'd3;
  localparam res_sel_t RES_DONE  = 3'd4;

  typedef struct packed {
    logic     capture;
    logic     order;
    logic     div_start;
    logic     setup;
    logic     out_load;
    res_sel_t out_sel;
    logic     advance;
  } cmd_t;

  typedef struct packed {
    logic line_active;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/aalr_in_if.sv @@
// input channel of the rasterizer core: valid/ready plus one command
// no dependencies
`default_nettype none

interface aalr_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aalr_out_if.sv @@
// result channel of the rasterizer core: valid/ready plus one pixel result
// no dependencies
`default_nettype none

interface aalr_out_if #(
  parameter int COORD_BITS    = 12,
  parameter int COVERAGE_BITS = 8
) ();
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  pixel_x;
  logic [COORD_BITS-1:0]  pixel_y;
  logic [COVERAGE_BITS:0] coverage;
  logic                   pixel_valid;
  logic                   line_done;
  logic                   last;

  modport source (output valid, pixel_x, pixel_y, coverage, pixel_valid, line_done, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, coverage, pixel_valid, line_done, last,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/aalr_divider.sv @@
// restoring divider for the slope, one quotient bit per cycle
// no dependencies; dividend must not exceed divisor
`default_nettype none

module aalr_divider #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] dividend,
  input  wire logic [COORD_BITS-1:0] divisor,
  output logic                       done,
  output logic [FRAC_BITS:0]         quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [COORD_BITS:0]  rem_r;
  logic [COORD_BITS:0]  rem_nxt;
  logic [COORD_BITS:0]  rem_sub;
  logic [FRAC_BITS:0]   q_r;
  logic [FRAC_BITS:0]   q_nxt;
  logic                 ge;

  always_comb begin
    ge      = rem_r >= {1'b0, divisor};
    rem_sub = ge ? (rem_r - {1'b0, divisor}) : rem_r;
    rem_nxt = {rem_sub[COORD_BITS-1:0], 1'b0};
    q_nxt   = {q_r[FRAC_BITS-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_BITS + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

@@ rtl/core/aalr_datapath.sv @@
// line setup, column stepping and result register of the rasterizer
// depends on aalr_pkg and aalr_divider
`default_nettype none

module aalr_datapath #(
  parameter int COORD_BITS    = 12,
  parameter int FRAC_BITS     = 16,
  parameter int COVERAGE_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire aalr_pkg::cmd_t         cmd,
  output aalr_pkg::sts_t              sts,
  input  wire logic [COORD_BITS-1:0]  start_x,
  input  wire logic [COORD_BITS-1:0]  start_y,
  input  wire logic [COORD_BITS-1:0]  end_x,
  input  wire logic [COORD_BITS-1:0]  end_y,
  output logic [COORD_BITS-1:0]       pixel_x,
  output logic [COORD_BITS-1:0]       pixel_y,
  output logic [COVERAGE_BITS:0]      coverage,
  output logic                        pixel_valid,
  output logic                        line_done,
  output logic                        last
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int V   = COVERAGE_BITS;
  localparam int ACC = C + F;
  localparam logic [V:0] FULL_COV = {1'b1, {V{1'b0}}};

  // capture stage
  logic [C-1:0] adx, ady;
  logic         steep_c;
  logic         steep_r;
  logic [C-1:0] a0_r, b0_r, a1_r, b1_r;

  // order stage
  logic         swap;
  logic [C-1:0] xo0, yo0, xo1, yo1;
  logic [C-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [C-1:0] dx_r, mag_r;
  logic         neg_r;

  // line state
  logic [F+1:0]   slope_r;
  logic [ACC-1:0] acc_r;
  logic [C-1:0]   column_r;
  logic [C-1:0]   last_col_r;
  logic           active_r;

  // setup
  logic           div_done;
  logic [F:0]     div_q;
  logic [F:0]     q_eff;
  logic [F+1:0]   slope_nxt;
  logic [ACC-1:0] acc_base;
  logic [ACC-1:0] acc_nxt;
  logic [ACC-1:0] slope_ext;

  // step values
  logic [C-1:0]   yi;
  logic [F+V-1:0] frac_pad;
  logic [V-1:0]   frac_cov;

  // result register
  logic [C-1:0] res_a, res_b;
  logic [V:0]   res_cov;
  logic         res_valid, res_done, res_last;
  logic [C-1:0] px_r, py_r;
  logic [V:0]   cov_r;
  logic         pvalid_r, done_r, last_r;

  always_comb begin
    adx     = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
    ady     = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
    steep_c = ady > adx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steep_r <= 1'b0;
    end else if (cmd.capture) begin
      steep_r <= steep_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a0_r <= steep_c ? start_y : start_x;
      b0_r <= steep_c ? start_x : start_y;
      a1_r <= steep_c ? end_y : end_x;
      b1_r <= steep_c ? end_x : end_y;
    end
  end

  always_comb begin
    swap = a0_r > a1_r;
    xo0  = swap ? a1_r : a0_r;
    yo0  = swap ? b1_r : b0_r;
    xo1  = swap ? a0_r : a1_r;
    yo1  = swap ? b0_r : b1_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.order) begin
      x0_r  <= xo0;
      y0_r  <= yo0;
      x1_r  <= xo1;
      y1_r  <= yo1;
      dx_r  <= swap ? (a0_r - a1_r) : (a1_r - a0_r);
      neg_r <= yo1 < yo0;
      mag_r <= (yo1 < yo0) ? (yo0 - yo1) : (yo1 - yo0);
    end
  end

  aalr_divider #(
    .COORD_BITS (C),
    .FRAC_BITS  (F)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_r),
    .divisor  (dx_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    q_eff     = (dx_r == '0) ? '0 : div_q;
    slope_nxt = neg_r ? ((F+2)'(0) - {1'b0, q_eff}) : {1'b0, q_eff};
    acc_base  = {y0_r, {F{1'b0}}};
    acc_nxt   = neg_r ? (acc_base - ACC'(q_eff)) : (acc_base + ACC'(q_eff));
    slope_ext = {{(C-2){slope_r[F+1]}}, slope_r};
    yi        = acc_r[ACC-1:F];
    frac_pad  = {acc_r[F-1:0], {V{1'b0}}};
    frac_cov  = frac_pad[F+V-1 -: V];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r    <= '0;
      acc_r      <= '0;
      column_r   <= '0;
      last_col_r <= '0;
      active_r   <= 1'b0;
    end else if (cmd.setup) begin
      slope_r  <= slope_nxt;
      acc_r    <= acc_nxt;
      active_r <= dx_r >= C'(2);
      if (dx_r >= C'(2)) begin
        column_r   <= x0_r + C'(1);
        last_col_r <= x1_r - C'(1);
      end else begin
        column_r   <= '0;
        last_col_r <= '0;
      end
    end else if (cmd.advance) begin
      if (column_r == last_col_r) begin
        active_r <= 1'b0;
      end else begin
        column_r <= column_r + C'(1);
        acc_r    <= acc_r + slope_ext;
      end
    end
  end

  always_comb begin
    res_a     = '0;
    res_b     = '0;
    res_cov   = '0;
    res_valid = 1'b0;
    res_done  = 1'b0;
    res_last  = 1'b0;
    case (cmd.out_sel)
      aalr_pkg::RES_EP0: begin
        res_a     = x0_r;
        res_b     = y0_r;
        res_cov   = FULL_COV;
        res_valid = 1'b1;
      end
      aalr_pkg::RES_EP1: begin
        res_a     = x1_r;
        res_b     = y1_r;
        res_cov   = FULL_COV;
        res_valid = 1'b1;
        res_last  = 1'b1;
      end
      aalr_pkg::RES_UPPER: begin
        res_a     = column_r;
        res_b     = yi;
        res_cov   = FULL_COV - {1'b0, frac_cov};
        res_valid = 1'b1;
      end
      aalr_pkg::RES_LOWER: begin
        res_a     = column_r;
        res_b     = yi + C'(1);
        res_cov   = {1'b0, frac_cov};
        res_valid = 1'b1;
        res_last  = 1'b1;
      end
      aalr_pkg::RES_DONE: begin
        res_done = 1'b1;
        res_last = 1'b1;
      end
      default: begin
        res_done = 1'b1;
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      px_r     <= steep_r ? res_b : res_a;
      py_r     <= steep_r ? res_a : res_b;
      cov_r    <= res_cov;
      pvalid_r <= res_valid;
      done_r   <= res_done;
      last_r   <= res_last;
    end
  end

  assign sts.line_active = active_r;
  assign sts.div_done    = div_done;

  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign coverage    = cov_r;
  assign pixel_valid = pvalid_r;
  assign line_done   = done_r;
  assign last        = last_r;

endmodule

`default_nettype wire

@@ rtl/core/aalr_controller.sv @@
// sequencer of the rasterizer: handshakes, setup steps and result order
// depends on aalr_pkg
`default_nettype none

module aalr_controller (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_opcode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire aalr_pkg::sts_t  sts,
  output aalr_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ORDER    = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT_A   = 3'd4;
  localparam logic [2:0] S_EMIT_B   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       step_mode_r, step_mode_nxt;
  logic       in_fire;

  always_comb begin
    in_ready  = (state_r == S_IDLE) || ((state_r == S_EMIT_B) && out_ready);
    out_valid = (state_r == S_EMIT_A) || (state_r == S_EMIT_B);
    in_fire   = in_valid && in_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    step_mode_nxt = step_mode_r;
    cmd           = '0;
    cmd.out_sel   = aalr_pkg::RES_DONE;
    case (state_r)
      S_IDLE, S_EMIT_B: begin
        if ((state_r == S_EMIT_B) && out_ready) begin
          state_nxt = S_IDLE;
        end
        if (in_fire) begin
          if (in_opcode == aalr_pkg::OP_LOAD) begin
            cmd.capture = 1'b1;
            state_nxt   = S_ORDER;
          end else if (sts.line_active) begin
            cmd.out_load  = 1'b1;
            cmd.out_sel   = aalr_pkg::RES_UPPER;
            step_mode_nxt = 1'b1;
            state_nxt     = S_EMIT_A;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = aalr_pkg::RES_DONE;
            state_nxt    = S_EMIT_B;
          end
        end
      end
      S_ORDER: begin
        cmd.order = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.setup     = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = aalr_pkg::RES_EP0;
          step_mode_nxt = 1'b0;
          state_nxt     = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        if (out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = step_mode_r ? aalr_pkg::RES_LOWER : aalr_pkg::RES_EP1;
          cmd.advance  = step_mode_r;
          state_nxt    = S_EMIT_B;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_mode_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_mode_r <= step_mode_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/antialiased_line_rasterizer_core.sv @@
// antialiased line rasterizer top level: controller plus datapath
// depends on aalr_pkg, aalr_in_if, aalr_out_if, aalr_controller, aalr_datapath
//
// Each command on in_chan is either a load (two endpoints) or a step. A load
// returns the two endpoints at full coverage, a step returns the upper and the
// lower pixel of the next interior column, or a single result with line_done
// set once the line is used up; the final result of each command has last set.
// A step sends its results one at a time through the single output register,
// and a step on a finished line sends only the line_done result. The steep
// test happens in the accept cycle. Before its second result can leave, a
// load passes through endpoint ordering, a divider start, the restoring slope
// divider at one quotient bit per cycle, and a step that loads the line state
// together with the first result. The next command is taken in the same
// cycle in which the final result of the previous one is taken by the sink.
`default_nettype none

module antialiased_line_rasterizer_core #(
  parameter int COORD_BITS    = 12,
  parameter int FRAC_BITS     = 16,
  parameter int COVERAGE_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  aalr_in_if.sink   in_chan,
  aalr_out_if.source out_chan
);

  aalr_pkg::cmd_t cmd;
  aalr_pkg::sts_t sts;

  aalr_controller u_controller (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  aalr_datapath #(
    .COORD_BITS    (COORD_BITS),
    .FRAC_BITS     (FRAC_BITS),
    .COVERAGE_BITS (COVERAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (in_chan.start_x),
    .start_y     (in_chan.start_y),
    .end_x       (in_chan.end_x),
    .end_y       (in_chan.end_y),
    .pixel_x     (out_chan.pixel_x),
    .pixel_y     (out_chan.pixel_y),
    .coverage    (out_chan.coverage),
    .pixel_valid (out_chan.pixel_valid),
    .line_done   (out_chan.line_done),
    .last        (out_chan.last)
  );

endmodule

`default_nettype wire

@@ rtl/core/aalr_port_checker.sv @@
// port-level checks for the rasterizer core, bound to the top level
// depends on antialiased_line_rasterizer_core_macros.svh
`default_nettype none

`include "antialiased_line_rasterizer_core_macros.svh"

module aalr_port_checker #(
  parameter int COVERAGE_BITS = 8
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COVERAGE_BITS:0] coverage,
  input wire logic                   pixel_valid,
  input wire logic                   line_done,
  input wire logic                   last
);

  localparam logic [COVERAGE_BITS:0] FULL_COV = {1'b1, {COVERAGE_BITS{1'b0}}};

  // a new transaction only enters when no result is pending or the last one leaves
  `AALR_ASSERT_NOW(a_accept_only_at_last, in_valid && in_ready, !out_valid || (out_ready && last))

  // an end-of-line result carries no pixel and closes its command
  `AALR_ASSERT_NOW(a_done_is_lone, out_valid && line_done, last && !pixel_valid)

  // coverage never exceeds full intensity
  `AALR_ASSERT_NOW(a_cov_range, out_valid, coverage <= FULL_COV)

  // stalled result holds
  `AALR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coverage) && $stable(last))

endmodule

bind antialiased_line_rasterizer_core aalr_port_checker #(
  .COVERAGE_BITS (COVERAGE_BITS)
) u_port_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .coverage    (out_chan.coverage),
  .pixel_valid (out_chan.pixel_valid),
  .line_done   (out_chan.line_done),
  .last        (out_chan.last)
);

`default_nettype wire
